FILE: rtl/core/utf8d_pkg.sv
package utf8d_pkg;

   localparam int BYTE_W = 8;
   localparam int CP_W   = 31;
   localparam int LEN_W  = 3;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
   localparam logic [LEN_W-1:0] LEN_2    = 3'd2;
   localparam logic [LEN_W-1:0] LEN_3    = 3'd3;
   localparam logic [LEN_W-1:0] LEN_4    = 3'd4;
   localparam logic [LEN_W-1:0] LEN_5    = 3'd5;
   localparam logic [LEN_W-1:0] LEN_6    = 3'd6;

   localparam logic [BYTE_W-1:0] ASCII_LO = 8'h00;
   localparam logic [BYTE_W-1:0] ASCII_HI = 8'h7f;
   localparam logic [BYTE_W-1:0] CONT_LO  = 8'h80;
   localparam logic [BYTE_W-1:0] CONT_HI  = 8'hbf;
   localparam logic [BYTE_W-1:0] LEAD2_LO = 8'hc0;
   localparam logic [BYTE_W-1:0] LEAD2_HI = 8'hdf;
   localparam logic [BYTE_W-1:0] LEAD3_LO = 8'he0;
   localparam logic [BYTE_W-1:0] LEAD3_HI = 8'hef;
   localparam logic [BYTE_W-1:0] LEAD4_LO = 8'hf0;
   localparam logic [BYTE_W-1:0] LEAD4_HI = 8'hf7;
   localparam logic [BYTE_W-1:0] LEAD5_LO = 8'hf8;
   localparam logic [BYTE_W-1:0] LEAD5_HI = 8'hfb;
   localparam logic [BYTE_W-1:0] LEAD6_LO = 8'hfc;
   localparam logic [BYTE_W-1:0] LEAD6_HI = 8'hfd;

   localparam logic [CP_W-1:0] MIN_LEN2 = 31'h80;
   localparam logic [CP_W-1:0] MIN_LEN3 = 31'h800;
   localparam logic [CP_W-1:0] MIN_LEN4 = 31'h10000;
   localparam logic [CP_W-1:0] MIN_LEN5 = 31'h200000;
   localparam logic [CP_W-1:0] MIN_LEN6 = 31'h4000000;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            is_ascii;
      logic            bad_sequence;
      logic            last_of_run;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } step_type;

endpackage

FILE: rtl/core/utf8d_req_if.sv
interface utf8d_req_if;
   logic                           valid;
   logic                           ready;
   logic [utf8d_pkg::BYTE_W-1:0]   in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

FILE: rtl/core/utf8d_rsp_if.sv
interface utf8d_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [utf8d_pkg::CP_W-1:0]   code_point;
   logic                         is_ascii;
   logic                         bad_sequence;
   logic                         last_of_run;

   modport source (output valid, output code_point, output is_ascii, output bad_sequence,
                   output last_of_run, input ready);
   modport sink (input valid, input code_point, input is_ascii, input bad_sequence,
                 input last_of_run, output ready);
endinterface

FILE: rtl/core/utf8d_decode.sv
module utf8d_decode (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step_en,
   input  logic [utf8d_pkg::BYTE_W-1:0]   in_byte,
   output utf8d_pkg::step_type            step
);

   logic [utf8d_pkg::LEN_W-1:0] exp_len_ff, exp_len_in;
   logic [utf8d_pkg::LEN_W-1:0] seen_ff, seen_in;
   logic [utf8d_pkg::CP_W-1:0]  acc_ff, acc_in;

   logic [utf8d_pkg::LEN_W-1:0] lead_len;
   logic [utf8d_pkg::CP_W-1:0]  lead_acc;
   logic                        lead_emit;
   utf8d_pkg::result_type       lead_res;
   utf8d_pkg::result_type       err_res;
   logic                        pending;
   logic [utf8d_pkg::CP_W-1:0]  acc_shift;
   logic [utf8d_pkg::LEN_W-1:0] seen_inc;
   logic [utf8d_pkg::CP_W-1:0]  min_val;

   always_comb begin
      err_res              = '0;
      err_res.bad_sequence = 1'b1;
   end

   always_comb begin
      lead_len  = utf8d_pkg::LEN_NONE;
      lead_acc  = '0;
      lead_emit = 1'b0;
      lead_res  = err_res;
      case (in_byte) inside
         [utf8d_pkg::ASCII_LO:utf8d_pkg::ASCII_HI]: begin
            lead_emit         = 1'b1;
            lead_res          = '0;
            lead_res.code_point = utf8d_pkg::CP_W'(in_byte);
            lead_res.is_ascii = 1'b1;
         end
         [utf8d_pkg::CONT_LO:utf8d_pkg::CONT_HI]: begin
            lead_emit = 1'b1;
         end
         [utf8d_pkg::LEAD2_LO:utf8d_pkg::LEAD2_HI]: begin
            lead_len = utf8d_pkg::LEN_2;
            lead_acc = utf8d_pkg::CP_W'(in_byte[4:0]);
         end
         [utf8d_pkg::LEAD3_LO:utf8d_pkg::LEAD3_HI]: begin
            lead_len = utf8d_pkg::LEN_3;
            lead_acc = utf8d_pkg::CP_W'(in_byte[3:0]);
         end
         [utf8d_pkg::LEAD4_LO:utf8d_pkg::LEAD4_HI]: begin
            lead_len = utf8d_pkg::LEN_4;
            lead_acc = utf8d_pkg::CP_W'(in_byte[2:0]);
         end
         [utf8d_pkg::LEAD5_LO:utf8d_pkg::LEAD5_HI]: begin
            lead_len = utf8d_pkg::LEN_5;
            lead_acc = utf8d_pkg::CP_W'(in_byte[1:0]);
         end
         [utf8d_pkg::LEAD6_LO:utf8d_pkg::LEAD6_HI]: begin
            lead_len = utf8d_pkg::LEN_6;
            lead_acc = utf8d_pkg::CP_W'(in_byte[0]);
         end
         default: begin
            lead_emit = 1'b1;
         end
      endcase
   end

   always_comb begin
      case (exp_len_ff)
         utf8d_pkg::LEN_2: min_val = utf8d_pkg::MIN_LEN2;
         utf8d_pkg::LEN_3: min_val = utf8d_pkg::MIN_LEN3;
         utf8d_pkg::LEN_4: min_val = utf8d_pkg::MIN_LEN4;
         utf8d_pkg::LEN_5: min_val = utf8d_pkg::MIN_LEN5;
         default:          min_val = utf8d_pkg::MIN_LEN6;
      endcase
   end

   assign pending   = (exp_len_ff >= utf8d_pkg::LEN_2) && (exp_len_ff <= utf8d_pkg::LEN_6);
   assign acc_shift = {acc_ff[utf8d_pkg::CP_W-7:0], in_byte[5:0]};
   assign seen_inc  = seen_ff + 3'd1;

   always_comb begin
      exp_len_in = exp_len_ff;
      seen_in    = seen_ff;
      acc_in     = acc_ff;
      step       = '0;
      if (!pending) begin
         exp_len_in   = lead_len;
         seen_in      = (lead_len != utf8d_pkg::LEN_NONE) ? 3'd1 : 3'd0;
         acc_in       = lead_acc;
         step.count   = {1'b0, lead_emit};
         step.first   = lead_res;
      end else if (!in_byte[7]) begin
         // drop the partial sequence, then retake the byte as ASCII
         exp_len_in   = utf8d_pkg::LEN_NONE;
         seen_in      = '0;
         acc_in       = '0;
         step.count   = 2'd2;
         step.first   = err_res;
         step.second  = lead_res;
         step.second.last_of_run = 1'b1;
      end else begin
         acc_in  = acc_shift;
         seen_in = seen_inc;
         if (seen_inc >= exp_len_ff) begin
            exp_len_in = utf8d_pkg::LEN_NONE;
            seen_in    = '0;
            acc_in     = '0;
            step.count = 2'd1;
            if (acc_shift < min_val) begin
               step.first = err_res;
            end else begin
               step.first.code_point = acc_shift;
            end
         end
      end
      if (step.count == 2'd1) begin
         step.first.last_of_run = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_len_ff <= utf8d_pkg::LEN_NONE;
         seen_ff    <= '0;
         acc_ff     <= '0;
      end else if (step_en) begin
         exp_len_ff <= exp_len_in;
         seen_ff    <= seen_in;
         acc_ff     <= acc_in;
      end
   end

   a_len_legal: assert property (@(posedge clock) disable iff (reset)
      (exp_len_ff == utf8d_pkg::LEN_NONE) || pending)
      else $error("expected length out of range");

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (exp_len_ff == utf8d_pkg::LEN_NONE) |-> (seen_ff == 3'd0))
      else $error("byte count set with no sequence pending");

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      pending |-> ((seen_ff >= 3'd1) && (seen_ff < exp_len_ff)))
      else $error("byte count outside pending sequence");

endmodule

FILE: rtl/core/utf8d_result_fifo.sv
module utf8d_result_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            push_cnt,
   input  utf8d_pkg::step_type   push_data,
   output logic                  room2,
   utf8d_rsp_if.source           rsp
);

   utf8d_pkg::result_type               entries_ff [utf8d_pkg::RSP_DEPTH];
   logic [utf8d_pkg::RSP_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [utf8d_pkg::RSP_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [utf8d_pkg::RSP_CNT_W-1:0]     count_ff, count_in;
   logic [utf8d_pkg::RSP_PTR_W-1:0]     wr_ptr_p1;
   logic [utf8d_pkg::RSP_PTR_W-1:0]     wr_ptr_p2;
   logic                                pop;

   function automatic logic [utf8d_pkg::RSP_PTR_W-1:0] ptr_inc(
      input logic [utf8d_pkg::RSP_PTR_W-1:0] p);
      if (p == utf8d_pkg::RSP_PTR_W'(utf8d_pkg::RSP_DEPTH - 1)) begin
         return '0;
      end
      return p + utf8d_pkg::RSP_PTR_W'(1);
   endfunction

   assign wr_ptr_p1 = ptr_inc(wr_ptr_ff);
   assign wr_ptr_p2 = ptr_inc(wr_ptr_p1);
   assign pop       = rsp.valid && rsp.ready;
   assign room2     = count_ff <= utf8d_pkg::RSP_CNT_W'(utf8d_pkg::RSP_DEPTH - 2);

   always_comb begin
      case (push_cnt)
         2'd1:    wr_ptr_in = wr_ptr_p1;
         2'd2:    wr_ptr_in = wr_ptr_p2;
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + utf8d_pkg::RSP_CNT_W'(push_cnt)
                  - utf8d_pkg::RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push_data.first;
      end
      if (push_cnt == 2'd2) begin
         entries_ff[wr_ptr_p1] <= push_data.second;
      end
   end

   assign rsp.valid        = count_ff != '0;
   assign rsp.code_point   = entries_ff[rd_ptr_ff].code_point;
   assign rsp.is_ascii     = entries_ff[rd_ptr_ff].is_ascii;
   assign rsp.bad_sequence = entries_ff[rd_ptr_ff].bad_sequence;
   assign rsp.last_of_run  = entries_ff[rd_ptr_ff].last_of_run;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push_cnt != 2'd0) |-> room2)
      else $error("result queue overflow");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= utf8d_pkg::RSP_CNT_W'(utf8d_pkg::RSP_DEPTH))
      else $error("result queue count out of range");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");

endmodule

FILE: rtl/core/utf8_stream_decoder_core.sv
// Byte-serial decoder for the original UTF-8 form (1 to 6 byte sequences, code
// points up to 31 bits). Each byte transaction on req_chan gives zero, one or two
// result transactions on rsp_chan: a pending sequence cut by a byte below 0x80
// yields an error and then the ASCII character. A byte is registered on accept and
// decoded into a four-entry result queue once that queue has room, so a result passes the
// input register and then the queue before it appears. One byte is taken per cycle while
// the queue holds two entries or fewer; results leave at one per cycle while rsp_chan is
// ready, so bytes that produce two results each fill the queue and stall the input.
module utf8_stream_decoder_core (
   input  logic          clock,
   input  logic          reset,
   utf8d_req_if.sink     req_chan,
   utf8d_rsp_if.source   rsp_chan
);

   logic                           in_vld_ff, in_vld_in;
   logic [utf8d_pkg::BYTE_W-1:0]   in_byte_ff;
   logic                           req_take;
   logic                           advance;
   logic                           room2;
   logic [1:0]                     push_cnt;
   utf8d_pkg::step_type            step;

   assign advance        = in_vld_ff && room2;
   assign req_chan.ready = !in_vld_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign push_cnt       = advance ? step.count : 2'd0;

   always_comb begin
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.in_byte;
      end
   end

   utf8d_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .in_byte (in_byte_ff),
      .step    (step)
   );

   utf8d_result_fifo u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .push_data (step),
      .room2     (room2),
      .rsp       (rsp_chan)
   );

   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !advance) |=> (in_vld_ff && $stable(in_byte_ff)))
      else $error("held byte lost while stalled");

   a_stall_ready: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !room2) |-> !req_chan.ready)
      else $error("byte taken while result queue is full");

endmodule
